[rtl/core/mandelbrot_escape_time_pixel_macros.svh]
// Assertion macros shared by the escape-time pixel RTL.
// Included by files that check their own control logic; no other dependencies.
`ifndef MANDELBROT_ESCAPE_TIME_PIXEL_MACROS_SVH
`define MANDELBROT_ESCAPE_TIME_PIXEL_MACROS_SVH
`ifndef SYNTHESIS
`define MANDEL_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define MANDEL_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define MANDEL_ASSERT(lbl, clk, rst_n, prop, msg)
`define MANDEL_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

[rtl/core/mandel_pkg.sv]
// Shared types and constants of the escape-time pixel block.
// No dependencies; used by every module in rtl/core.
package mandel_pkg;

	localparam int FRAC    = 28;
	localparam int DIM_MAX = 4096;
	localparam int ZW      = 32;
	localparam int CW      = 48;
	localparam int SUMW    = 49;
	localparam int NUMW    = 44;
	localparam int DVSW    = 13;
	localparam int REMW    = 12;
	localparam int CNTW    = 16;
	localparam int IDXW    = 3;
	localparam int CFGW    = 32;

	localparam logic [IDXW-1:0] REG_WIDTH  = 3'd0;
	localparam logic [IDXW-1:0] REG_HEIGHT = 3'd1;
	localparam logic [IDXW-1:0] REG_LEFT   = 3'd2;
	localparam logic [IDXW-1:0] REG_TOP    = 3'd3;
	localparam logic [IDXW-1:0] REG_RIGHT  = 3'd4;
	localparam logic [IDXW-1:0] REG_BOTTOM = 3'd5;
	localparam logic [IDXW-1:0] REG_LIMIT  = 3'd6;

	typedef struct packed {
		logic [11:0] pixel_col;
		logic [11:0] pixel_row;
	} in_item_t;

	typedef struct packed {
		logic [11:0]     out_col;
		logic [11:0]     out_row;
		logic            in_set;
		logic [CNTW-1:0] escape_count;
		logic [7:0]      gray_level;
	} out_item_t;

	typedef struct packed {
		logic [REMW-1:0] rem;
		logic [NUMW-1:0] num;
		logic [DVSW-1:0] dvs;
	} div_lane_t;

	typedef struct packed {
		logic      valid;
		div_lane_t re;
		div_lane_t im;
	} div_stage_t;

	typedef struct packed {
		logic            in_set;
		logic [CNTW-1:0] count;
	} iter_res_t;

endpackage

[rtl/core/mandel_div_cell.sv]
// One restoring division step on both axis lanes, registered.
// Depends on mandel_pkg.
module mandel_div_cell (
	input  logic                   clk,
	input  logic                   arst_n,
	input  mandel_pkg::div_stage_t d,
	output mandel_pkg::div_stage_t q
);

	logic      valid_s1;
	mandel_pkg::div_lane_t re_s1, im_s1;

	function automatic mandel_pkg::div_lane_t step(input mandel_pkg::div_lane_t l);
		mandel_pkg::div_lane_t r;
		logic [mandel_pkg::DVSW-1:0] t;
		logic ge;
		t = {l.rem, l.num[mandel_pkg::NUMW-1]};
		ge = (t >= l.dvs);
		r.dvs = l.dvs;
		r.rem = mandel_pkg::REMW'(ge ? t - l.dvs : t);
		r.num = {l.num[mandel_pkg::NUMW-2:0], ge};
		return r;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= d.valid;
		end
	end

	always_ff @(posedge clk) begin
		re_s1 <= step(d.re);
		im_s1 <= step(d.im);
	end

	assign q = '{valid: valid_s1, re: re_s1, im: im_s1};

endmodule

[rtl/core/mandel_div_chain.sv]
// Row of division cells, one quotient bit per cell, for both axes at once.
// Depends on mandel_pkg and mandel_div_cell.
module mandel_div_chain (
	input  logic                   clk,
	input  logic                   arst_n,
	input  mandel_pkg::div_stage_t head,
	output mandel_pkg::div_stage_t tail
);

	mandel_pkg::div_stage_t link [mandel_pkg::NUMW+1];

	assign link[0] = head;

	for (genvar i = 0; i < mandel_pkg::NUMW; i++) begin : g_cell
		mandel_div_cell u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.d     (link[i]),
			.q     (link[i+1])
		);
	end

	assign tail = link[mandel_pkg::NUMW];

endmodule

[rtl/core/mandel_iter.sv]
// Escape-time iteration core: one z = z*z + c update and escape test per cycle while in the run state.
// Depends on mandel_pkg.
module mandel_iter (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic signed [mandel_pkg::CW-1:0] cr,
	input  logic signed [mandel_pkg::CW-1:0] ci,
	input  logic [mandel_pkg::CNTW-1:0]    limit,
	input  logic                           take,
	output logic                           busy,
	output logic                           res_valid,
	output mandel_pkg::iter_res_t          res
);

	typedef enum logic [1:0] {C_IDLE, C_RUN, C_HOLD} cstate_t;

	localparam logic signed [mandel_pkg::SUMW-1:0] SAT_HI =
		mandel_pkg::SUMW'(64'sd3 <<< mandel_pkg::FRAC);
	localparam logic signed [mandel_pkg::SUMW-1:0] SAT_LO = -SAT_HI;
	localparam logic signed [63:0] THR = 64'sd1 <<< (2 * mandel_pkg::FRAC + 2);

	cstate_t state_q;
	logic signed [mandel_pkg::ZW-1:0] zr_q, zi_q;
	logic signed [mandel_pkg::CW-1:0] cr_q, ci_q;
	logic [mandel_pkg::CNTW-1:0] lim_q, k_q;
	mandel_pkg::iter_res_t res_q;

	logic signed [63:0] pr, pi, px, mag2, dif, re_s, im_s;
	logic signed [mandel_pkg::SUMW-1:0] re_sum, im_sum;
	logic signed [mandel_pkg::ZW-1:0] zr_n, zi_n;
	logic esc;

	function automatic logic signed [mandel_pkg::ZW-1:0] sat3(
		input logic signed [mandel_pkg::SUMW-1:0] v);
		logic signed [mandel_pkg::SUMW-1:0] r;
		if (v > SAT_HI) r = SAT_HI;
		else if (v < SAT_LO) r = SAT_LO;
		else r = v;
		return mandel_pkg::ZW'(r);
	endfunction

	always_comb begin
		pr     = zr_q * zr_q;
		pi     = zi_q * zi_q;
		px     = zr_q * zi_q;
		mag2   = pr + pi;
		dif    = pr - pi;
		re_s   = dif >>> mandel_pkg::FRAC;
		im_s   = px >>> (mandel_pkg::FRAC - 1);
		re_sum = mandel_pkg::SUMW'(re_s) + mandel_pkg::SUMW'(cr_q);
		im_sum = mandel_pkg::SUMW'(im_s) + mandel_pkg::SUMW'(ci_q);
		zr_n   = sat3(re_sum);
		zi_n   = sat3(im_sum);
		esc    = (k_q != '0) && (mag2 > THR);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
		end else begin
			unique case (state_q)
				C_IDLE: if (start) state_q <= C_RUN;
				C_RUN:  if (esc || k_q == lim_q) state_q <= C_HOLD;
				C_HOLD: if (take) state_q <= C_IDLE;
				default: state_q <= C_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == C_IDLE && start) begin
			cr_q  <= cr;
			ci_q  <= ci;
			lim_q <= limit;
			k_q   <= '0;
			zr_q  <= '0;
			zi_q  <= '0;
		end else if (state_q == C_RUN) begin
			if (esc) begin
				res_q <= '{in_set: 1'b0, count: k_q - 1'b1};
			end else if (k_q == lim_q) begin
				res_q <= '{in_set: 1'b1, count: '0};
			end else begin
				zr_q <= zr_n;
				zi_q <= zi_n;
				k_q  <= k_q + 1'b1;
			end
		end
	end

	assign busy      = (state_q != C_IDLE);
	assign res_valid = (state_q == C_HOLD);
	assign res       = res_q;

endmodule

[rtl/core/mandelbrot_escape_time_pixel.sv]
// Escape-time pixel top: config registers, viewport mapping, division chain,
// iteration core and output register. Depends on mandel_pkg and all mandel_* modules.
// An item passes the mapping state, the 44-cell division chain, the iteration core and
// the core's hold state in turn before its result is loaded into the output register.
// One item at a time: the input stalls until the result of the last item is taken.
// Reset restores the default viewport and limit and clears all control state.
`include "mandelbrot_escape_time_pixel_macros.svh"
module mandelbrot_escape_time_pixel (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  mandel_pkg::in_item_t          in_item,
	output logic                          out_valid,
	input  logic                          out_stall,
	output mandel_pkg::out_item_t         out_item,
	input  logic                          cfg_we,
	input  logic [mandel_pkg::IDXW-1:0]   cfg_index,
	input  logic [mandel_pkg::CFGW-1:0]   cfg_data
);

	typedef enum logic [1:0] {S_IDLE, S_MAP, S_DIV, S_ITER} state_t;

	state_t state_q;
	logic [mandel_pkg::DVSW-1:0] width_q, height_q;
	logic [31:0] left_q, top_q, right_q, bottom_q;
	logic [mandel_pkg::CNTW-1:0] limit_q;
	mandel_pkg::in_item_t pix_q;
	logic zw_q, zh_q, nr_q, ni_q;
	logic out_valid_q;
	mandel_pkg::out_item_t out_q;

	logic signed [32:0] span_r, span_i;
	logic [31:0] mag_r, mag_i;
	logic [mandel_pkg::DVSW-1:0] dv_r, dv_i;
	mandel_pkg::div_stage_t head, tail;
	logic signed [mandel_pkg::CW-1:0] base_r, base_i, q_r, q_i, cr, ci;
	logic start, busy, res_valid, take;
	mandel_pkg::iter_res_t res;

	function automatic logic [mandel_pkg::DVSW-1:0] clamp_dim(
		input logic [mandel_pkg::DVSW-1:0] s);
		if (s == '0) return mandel_pkg::DVSW'(1);
		if (s > mandel_pkg::DVSW'(mandel_pkg::DIM_MAX)) return mandel_pkg::DVSW'(mandel_pkg::DIM_MAX);
		return s;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 13'd640;
			height_q <= 13'd480;
			left_q   <= 32'hE000_0000;
			top_q    <= 32'h1400_0000;
			right_q  <= 32'h0800_0000;
			bottom_q <= 32'hEC00_0000;
			limit_q  <= 16'd255;
		end else if (cfg_we) begin
			unique case (cfg_index)
				mandel_pkg::REG_WIDTH:  width_q  <= cfg_data[mandel_pkg::DVSW-1:0];
				mandel_pkg::REG_HEIGHT: height_q <= cfg_data[mandel_pkg::DVSW-1:0];
				mandel_pkg::REG_LEFT:   left_q   <= cfg_data;
				mandel_pkg::REG_TOP:    top_q    <= cfg_data;
				mandel_pkg::REG_RIGHT:  right_q  <= cfg_data;
				mandel_pkg::REG_BOTTOM: bottom_q <= cfg_data;
				mandel_pkg::REG_LIMIT:  limit_q  <= cfg_data[mandel_pkg::CNTW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		span_r = $signed({right_q[31], right_q}) - $signed({left_q[31], left_q});
		span_i = $signed({bottom_q[31], bottom_q}) - $signed({top_q[31], top_q});
		mag_r  = 32'(span_r[32] ? -span_r : span_r);
		mag_i  = 32'(span_i[32] ? -span_i : span_i);
		dv_r   = clamp_dim(width_q);
		dv_i   = clamp_dim(height_q);
		head.valid  = (state_q == S_MAP);
		head.re.rem = '0;
		head.re.num = mandel_pkg::NUMW'(mag_r) * mandel_pkg::NUMW'(pix_q.pixel_col);
		head.re.dvs = dv_r;
		head.im.rem = '0;
		head.im.num = mandel_pkg::NUMW'(mag_i) * mandel_pkg::NUMW'(pix_q.pixel_row);
		head.im.dvs = dv_i;
	end

	mandel_div_chain u_chain (
		.clk   (clk),
		.arst_n(arst_n),
		.head  (head),
		.tail  (tail)
	);

	always_comb begin
		base_r = mandel_pkg::CW'($signed(left_q));
		base_i = mandel_pkg::CW'($signed(top_q));
		q_r    = zw_q ? '0 : mandel_pkg::CW'(tail.re.num);
		q_i    = zh_q ? '0 : mandel_pkg::CW'(tail.im.num);
		cr     = nr_q ? base_r - q_r : base_r + q_r;
		ci     = ni_q ? base_i - q_i : base_i + q_i;
		start  = (state_q == S_DIV) && tail.valid;
		take   = res_valid && (!out_valid_q || !out_stall);
	end

	mandel_iter u_iter (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.cr       (cr),
		.ci       (ci),
		.limit    (limit_q),
		.take     (take),
		.busy     (busy),
		.res_valid(res_valid),
		.res      (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: if (in_valid) state_q <= S_MAP;
				S_MAP:  state_q <= S_DIV;
				S_DIV:  if (tail.valid) state_q <= S_ITER;
				S_ITER: if (take) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
			if (take) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) pix_q <= in_item;
		if (state_q == S_MAP) begin
			zw_q <= (width_q == '0);
			zh_q <= (height_q == '0);
			nr_q <= span_r[32];
			ni_q <= span_i[32];
		end
		if (take) begin
			out_q.out_col      <= pix_q.pixel_col;
			out_q.out_row      <= pix_q.pixel_row;
			out_q.in_set       <= res.in_set;
			out_q.escape_count <= res.count;
			out_q.gray_level   <= res.count[7:0];
		end
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	`MANDEL_ASSERT(a_accept_blocks, clk, arst_n, (in_valid && !in_stall) |=> in_stall, "item accepted while busy")
	`MANDEL_NEVER(a_idle_core, clk, arst_n, !in_stall && busy, "input open while core busy")
	`MANDEL_NEVER(a_chain_state, clk, arst_n, tail.valid && state_q != S_DIV, "quotient outside divide state")
	`MANDEL_ASSERT(a_take_loads, clk, arst_n, take |=> out_valid, "result taken but not shown")

endmodule

[bench/tb.sv]
// Self-checking testbench for mandelbrot_escape_time_pixel: pixel items are driven
// through random gaps and stalls and each result is checked against a local escape-time
// predictor. Depends on mandel_pkg and the RTL under rtl/core.
module tb;

	localparam logic [mandel_pkg::IDXW-1:0] REG_SPARE = 3'd7;
	localparam int HOLD_CYCLES = 1500;
	localparam int WATCHDOG = 300000;
	localparam longint ONE_Q = 64'sd1 << mandel_pkg::FRAC;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	mandel_pkg::in_item_t in_item;
	logic out_valid;
	logic out_stall;
	mandel_pkg::out_item_t out_item;
	logic cfg_we;
	logic [mandel_pkg::IDXW-1:0] cfg_index;
	logic [mandel_pkg::CFGW-1:0] cfg_data;

	logic [12:0] view_width;
	logic [12:0] view_height;
	logic signed [31:0] view_left;
	logic signed [31:0] view_top;
	logic signed [31:0] view_right;
	logic signed [31:0] view_bottom;
	logic [15:0] iter_limit;

	mandel_pkg::out_item_t pixel_results[$];
	int errors;
	int idle_cycles;
	bit quiet;
	int hold_req;
	int hold_seen;

	mandelbrot_escape_time_pixel DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_item(in_item),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_item(out_item),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic longint map_axis(longint base, longint far_end, longint pixel,
			longint size);
		longint span;
		longint q;
		if (size == 0)
			return base;
		if (size > mandel_pkg::DIM_MAX)
			size = mandel_pkg::DIM_MAX;
		span = far_end - base;
		q = ((span < 0) ? -span : span) * pixel / size;
		return (span < 0) ? base - q : base + q;
	endfunction

	function automatic longint clamp3(longint v);
		if (v > 3 * ONE_Q)
			return 3 * ONE_Q;
		if (v < -3 * ONE_Q)
			return -3 * ONE_Q;
		return v;
	endfunction

	function automatic mandel_pkg::out_item_t escape_pixel(mandel_pkg::in_item_t it);
		mandel_pkg::out_item_t r;
		longint cr;
		longint ci;
		longint zr;
		longint zi;
		longint re2;
		longint im2;
		int n;
		bit escaped;
		int count;
		cr = map_axis(view_left, view_right, it.pixel_col, view_width);
		ci = map_axis(view_top, view_bottom, it.pixel_row, view_height);
		zr = 0;
		zi = 0;
		escaped = 0;
		count = 0;
		for (n = 0; n < iter_limit; n++) begin
			re2 = (zr * zr - zi * zi) >>> mandel_pkg::FRAC;
			im2 = (zr * zi) >>> (mandel_pkg::FRAC - 1);
			zr = clamp3(re2 + cr);
			zi = clamp3(im2 + ci);
			if (zr * zr + zi * zi > (64'sd4 << (2 * mandel_pkg::FRAC))) begin
				escaped = 1;
				count = n;
				break;
			end
		end
		r.out_col = it.pixel_col;
		r.out_row = it.pixel_row;
		r.in_set = !escaped;
		r.escape_count = escaped ? count[15:0] : '0;
		r.gray_level = escaped ? count[7:0] : '0;
		return r;
	endfunction

	function automatic int pick_gap();
		int r;
		if (quiet)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 95)
			return $urandom_range(1, 4);
		return $urandom_range(10, 60);
	endfunction

	task automatic send_pixel(input logic [11:0] col, input logic [11:0] row);
		int gap;
		mandel_pkg::in_item_t it;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		it.pixel_col = col;
		it.pixel_row = row;
		in_item <= it;
		in_valid <= 1'b1;
		do
			@(posedge clk);
		while (in_stall);
		pixel_results.insert(pixel_results.size(), escape_pixel(it));
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		wait (pixel_results.size() == 0);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(input logic [mandel_pkg::IDXW-1:0] idx,
			input logic [mandel_pkg::CFGW-1:0] data);
		drain();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			mandel_pkg::REG_WIDTH: view_width = data[12:0];
			mandel_pkg::REG_HEIGHT: view_height = data[12:0];
			mandel_pkg::REG_LEFT: view_left = data;
			mandel_pkg::REG_TOP: view_top = data;
			mandel_pkg::REG_RIGHT: view_right = data;
			mandel_pkg::REG_BOTTOM: view_bottom = data;
			mandel_pkg::REG_LIMIT: iter_limit = data[15:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic set_view(input logic [12:0] w, input logic [12:0] h,
			input logic [31:0] l, input logic [31:0] t, input logic [31:0] r,
			input logic [31:0] b, input logic [15:0] lim);
		write_reg(mandel_pkg::REG_WIDTH, mandel_pkg::CFGW'(w));
		write_reg(mandel_pkg::REG_HEIGHT, mandel_pkg::CFGW'(h));
		write_reg(mandel_pkg::REG_LEFT, l);
		write_reg(mandel_pkg::REG_TOP, t);
		write_reg(mandel_pkg::REG_RIGHT, r);
		write_reg(mandel_pkg::REG_BOTTOM, b);
		write_reg(mandel_pkg::REG_LIMIT, mandel_pkg::CFGW'(lim));
	endtask

	task automatic test_default_view();
		send_pixel(12'd0, 12'd0);
		send_pixel(12'd639, 12'd479);
		send_pixel(12'd512, 12'd240);
		send_pixel(12'd400, 12'd200);
		send_pixel(12'd4095, 12'd4095);
		send_pixel(12'd4095, 12'd0);
		send_pixel(12'd0, 12'd4095);
		send_pixel(12'hAAA, 12'h555);
		send_pixel(12'h555, 12'hAAA);
	endtask

	task automatic test_corner_cases();
		// zero divisors and zero limit
		set_view(13'd0, 13'd0, 32'hE000_0000, 32'h0400_0000, 32'h0800_0000,
			32'hFC00_0000, 16'd0);
		send_pixel(12'd100, 12'd100);
		write_reg(mandel_pkg::REG_LIMIT, 32'd40);
		send_pixel(12'd4095, 12'd7);
		// oversized divisors, clamped to the maximum dimension
		write_reg(mandel_pkg::REG_WIDTH, 32'd8191);
		write_reg(mandel_pkg::REG_HEIGHT, 32'd5000);
		send_pixel(12'd4095, 12'd4095);
		send_pixel(12'd2048, 12'd1024);
		// escape on first update, full-range bounds
		set_view(13'd1, 13'd1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
			32'h7FFF_FFFF, 16'd1);
		send_pixel(12'd0, 12'd0);
		send_pixel(12'd1, 12'd1);
		send_pixel(12'd4095, 12'd4095);
		write_reg(mandel_pkg::REG_LIMIT, 32'hFFFF_FFFF);
		send_pixel(12'd3, 12'd2);
		// unmapped register index must be ignored
		write_reg(REG_SPARE, 32'h1234_5678);
		write_reg(mandel_pkg::REG_LIMIT, 32'd300);
		write_reg(mandel_pkg::REG_WIDTH, 32'd4096);
		send_pixel(12'd0, 12'd0);
	endtask

	task automatic test_random_views(input int phases, input int per_phase);
		int p;
		int k;
		int r;
		logic [12:0] w;
		logic [12:0] h;
		logic [15:0] lim;
		logic [31:0] l;
		logic [31:0] t;
		logic [31:0] rr;
		logic [31:0] b;
		for (p = 0; p < phases; p++) begin
			r = $urandom_range(0, 19);
			w = (r == 0) ? 13'd0 : (r == 1) ? 13'($urandom_range(4097, 8191)) :
				13'($urandom_range(1, (r < 12) ? 64 : 4096));
			r = $urandom_range(0, 19);
			h = (r == 0) ? 13'd0 : (r == 1) ? 13'($urandom_range(4097, 8191)) :
				13'($urandom_range(1, (r < 12) ? 64 : 4096));
			r = $urandom_range(0, 19);
			lim = (r == 0) ? 16'd0 : (r < 3) ? 16'd255 : 16'($urandom_range(1, 64));
			if ($urandom_range(0, 4) == 0) begin
				l = $urandom;
				t = $urandom;
				rr = $urandom;
				b = $urandom;
			end else begin
				l = 32'($signed($urandom_range(0, 32'h3000_0000)) - 32'sh2000_0000);
				t = 32'($signed($urandom_range(0, 32'h3000_0000)) - 32'sh1800_0000);
				rr = 32'($signed($urandom_range(0, 32'h3000_0000)) - 32'sh1000_0000);
				b = 32'($signed($urandom_range(0, 32'h3000_0000)) - 32'sh1800_0000);
			end
			set_view(w, h, l, t, rr, b, lim);
			quiet = ($urandom_range(0, 5) == 0);
			for (k = 0; k < per_phase; k++) begin
				if ($urandom_range(0, 9) < 8 && w != 0 && h != 0)
					send_pixel(12'($urandom_range(0, (w > 4096 ? 4096 : w) - 1)),
						12'($urandom_range(0, (h > 4096 ? 4096 : h) - 1)));
				else
					send_pixel(12'($urandom), 12'($urandom));
			end
			quiet = 0;
		end
	endtask

	task automatic test_output_hold();
		int k;
		set_view(13'd64, 13'd64, 32'hE000_0000, 32'h1000_0000, 32'h0800_0000,
			32'hF000_0000, 16'd16);
		quiet = 1;
		hold_req++;
		for (k = 0; k < 20; k++)
			send_pixel(12'($urandom_range(0, 63)), 12'($urandom_range(0, 63)));
		quiet = 0;
	endtask

	task automatic test_sender_pause();
		int k;
		for (k = 0; k < 10; k++)
			send_pixel(12'($urandom_range(0, 63)), 12'($urandom_range(0, 63)));
		drain();
		for (k = 0; k < 10; k++)
			send_pixel(12'($urandom_range(0, 63)), 12'($urandom_range(0, 63)));
	endtask

	task automatic test_deep_limit();
		set_view(13'd4, 13'd4, 32'h0000_0000, 32'h0000_0000, 32'hE000_0000,
			32'h1000_0000, 16'd65535);
		send_pixel(12'd0, 12'd0);
		send_pixel(12'd3, 12'd3);
		send_pixel(12'd2, 12'd1);
		write_reg(mandel_pkg::REG_LIMIT, 32'd4000);
		send_pixel(12'd1, 12'd1);
		send_pixel(12'd3, 12'd0);
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_item = '0;
		out_stall = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		errors = 0;
		quiet = 0;
		hold_req = 0;
		view_width = 13'd640;
		view_height = 13'd480;
		view_left = 32'hE000_0000;
		view_top = 32'h1400_0000;
		view_right = 32'h0800_0000;
		view_bottom = 32'hEC00_0000;
		iter_limit = 16'd255;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_default_view();
		test_corner_cases();
		test_output_hold();
		test_sender_pause();
		test_random_views(20, 48);
		test_deep_limit();
		drain();
		repeat (100) @(posedge clk);
		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	initial begin
		hold_seen = 0;
		forever begin
			@(posedge clk);
			if (hold_seen != hold_req) begin
				hold_seen = hold_req;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				out_stall <= 1'b0;
			end else if (!quiet && $urandom_range(0, 99) < 30) begin
				out_stall <= 1'b1;
				if ($urandom_range(0, 9) == 0)
					repeat ($urandom_range(10, 80)) @(posedge clk);
				else
					repeat ($urandom_range(1, 4)) @(posedge clk);
				out_stall <= 1'b0;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		mandel_pkg::out_item_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pixel_results.size() == 0) begin
				$display("%0t: unexpected result %p", $time, out_item);
				errors++;
			end else begin
				want = pixel_results.pop_front();
				if (want.out_col !== out_item.out_col) begin
					$display("%0t: out_col expected %0d got %0d", $time,
						want.out_col, out_item.out_col);
					errors++;
				end
				if (want.out_row !== out_item.out_row) begin
					$display("%0t: out_row expected %0d got %0d", $time,
						want.out_row, out_item.out_row);
					errors++;
				end
				if (want.in_set !== out_item.in_set) begin
					$display("%0t: in_set expected %0d got %0d", $time,
						want.in_set, out_item.in_set);
					errors++;
				end
				if (want.escape_count !== out_item.escape_count) begin
					$display("%0t: escape_count expected %0d got %0d", $time,
						want.escape_count, out_item.escape_count);
					errors++;
				end
				if (want.gray_level !== out_item.gray_level) begin
					$display("%0t: gray_level expected %0d got %0d", $time,
						want.gray_level, out_item.gray_level);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
			idle_cycles <= 0;
		else if (idle_cycles >= WATCHDOG) begin
			$display("%0t: no progress for %0d cycles", $time, WATCHDOG);
			$display("status: fail");
			$finish;
		end else
			idle_cycles <= idle_cycles + 1;
	end

endmodule

[files.f]
+incdir+rtl/core
rtl/core/mandel_pkg.sv
rtl/core/mandel_div_cell.sv
rtl/core/mandel_div_chain.sv
rtl/core/mandel_iter.sv
rtl/core/mandelbrot_escape_time_pixel.sv
bench/tb.sv
